@@ rtl/iid_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iid_pkg
// Shared types and constants for the interrupt inject and dispatch block.
// ----------------------------------------------------------------------------
package iid_pkg;

  localparam int NUM_GENERATORS = 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_STEP   = 2'd2,
    OP_RESUME = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_NO_GEN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SAVE_NONE = 2'd0,
    SAVE_EI   = 2'd1,
    SAVE_FE   = 2'd2
  } save_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY,
    ST_DONE
  } state_t;

  localparam logic [2:0]  KIND_RESET   = 3'd0;
  localparam logic [2:0]  KIND_NMI     = 3'd1;
  localparam logic [2:0]  KIND_MASK_LO = 3'd2;

  localparam int          PSW_ID       = 5;
  localparam int          PSW_EP       = 6;
  localparam int          PSW_NP       = 7;
  localparam logic [31:0] RESET_PSW    = 32'h0000_0020;
  localparam logic [31:0] NMI_CODE     = 32'h0000_0010;
  localparam logic [31:0] ECR_LO_MASK  = 32'h0000_ffff;
  localparam logic [31:0] ECR_HI_MASK  = 32'hffff_0000;
  localparam logic [7:0]  MASK_CODE_LO = 8'h80;

  typedef struct packed {
    logic        valid;
    logic        enabled;
    logic [2:0]  kind;
    logic        cond;
    logic [31:0] value;
    logic [7:0]  id;
  } gen_entry_t;

  typedef struct packed {
    logic take_prev;
    logic take_next;
    logic disable_gen;
  } cell_ctrl_t;

  typedef struct packed {
    logic pc_hit;
    logic time_hit;
    logic id_hit;
    logic nm;
  } cell_hit_t;

endpackage
`default_nettype wire

@@ rtl/interrupt_inject_dispatch_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// interrupt_inject_dispatch_top
// Generator table as a chain of slot cells, newest in cell 0, with the
// interrupt entry computation for each retired instruction.
//
//   channel  | handshake           | fields
//   ---------+---------------------+--------------------------------------
//   command  | start / busy        | operation int_kind cond_kind cond_value
//            |                     | gen_number old_pc cur_pc psw_in ecr_in
//   result   | done (one cycle)    | status assigned_number taken next_pc
//            |                     | next_psw next_ecr save_kind save_pc save_psw
//
// A transfer runs from accept to the result strobe through ST_IDLE (load),
// ST_EVAL (every cell compares in parallel), ST_APPLY (resolve the newest hit,
// update the chain) and ST_DONE (strobe). busy is low only in ST_IDLE, so it
// is high after accept through the strobe cycle. Reset empties the table,
// sets the next number to one and clears the step count and pending NMI.
// The result is shown for exactly one cycle and is never held off.
// ----------------------------------------------------------------------------
module interrupt_inject_dispatch_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [2:0]  int_kind,
  input  logic        cond_kind,
  input  logic [31:0] cond_value,
  input  logic [7:0]  gen_number,
  input  logic [31:0] old_pc,
  input  logic [31:0] cur_pc,
  input  logic [31:0] psw_in,
  input  logic [31:0] ecr_in,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  assigned_number,
  output logic        taken,
  output logic [31:0] next_pc,
  output logic [31:0] next_psw,
  output logic [31:0] next_ecr,
  output logic [1:0]  save_kind,
  output logic [31:0] save_pc,
  output logic [31:0] save_psw
);

  localparam int N = iid_pkg::NUM_GENERATORS;

  iid_pkg::state_t     state, state_next;
  iid_pkg::op_t        op_q;
  logic [2:0]          kind_q;
  logic                cond_q;
  logic [31:0]         value_q;
  logic [7:0]          num_q;
  logic [31:0]         old_pc_q;
  logic [31:0]         cur_pc_q;
  logic [31:0]         psw_q;
  logic [31:0]         ecr_q;
  logic [31:0]         step_count;
  logic [7:0]          next_id;
  logic                nmi_pending, nmi_pending_next;

  iid_pkg::gen_entry_t entries [N];
  iid_pkg::cell_ctrl_t ctrl    [N];
  iid_pkg::cell_hit_t  hits    [N];
  iid_pkg::gen_entry_t new_entry, empty_entry;

  logic [N-1:0] valid_vec;
  logic [N-1:0] nm_vec;
  logic [N-1:0] pc_hit_q, time_hit_q, id_hit_q;
  logic         any_q, nm_q;
  logic         accept;

  logic [N-1:0] match, first, id_first, id_ge, disable_vec;
  logic [2:0]   sel_kind, fire_kind;
  logic         check, fire, table_full;
  logic [31:0]  mod_psw;
  logic [2:0]   mask_idx;
  logic [7:0]   mask_code;

  logic [1:0]   status_next;
  logic [7:0]   assigned_next;
  logic         taken_next;
  logic [31:0]  next_pc_next;
  logic [31:0]  next_psw_next;
  logic [31:0]  next_ecr_next;
  logic [1:0]   save_kind_next;
  logic [31:0]  save_pc_next;
  logic [31:0]  save_psw_next;

  assign accept = start && !busy;

  always_comb begin
    new_entry.valid   = 1'b1;
    new_entry.enabled = 1'b1;
    new_entry.kind    = kind_q;
    new_entry.cond    = cond_q;
    new_entry.value   = value_q;
    new_entry.id      = next_id;
    empty_entry       = '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    iid_pkg::gen_entry_t prev_e, next_e;
    if (i == 0) begin : g_head
      assign prev_e = new_entry;
    end else begin : g_body
      assign prev_e = entries[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_e = empty_entry;
    end else begin : g_inner
      assign next_e = entries[i+1];
    end

    iid_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl[i]),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .old_pc     (old_pc_q),
      .step_count (step_count),
      .gen_number (num_q),
      .entry      (entries[i]),
      .hit        (hits[i])
    );

    assign valid_vec[i] = entries[i].valid;
    assign nm_vec[i]    = hits[i].nm;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iid_pkg::ST_IDLE:  if (start) state_next = iid_pkg::ST_EVAL;
      iid_pkg::ST_EVAL:  state_next = iid_pkg::ST_APPLY;
      iid_pkg::ST_APPLY: state_next = iid_pkg::ST_DONE;
      iid_pkg::ST_DONE:  state_next = iid_pkg::ST_IDLE;
      default:           state_next = iid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      iid_pkg::ST_IDLE: busy = 1'b0;
      iid_pkg::ST_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the step count on a step (saturating) and clear it on a resume.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
    end else if (accept) begin
      if (iid_pkg::op_t'(operation) == iid_pkg::OP_RESUME) begin
        step_count <= '0;
      end else if ((iid_pkg::op_t'(operation) == iid_pkg::OP_STEP) && (step_count != '1)) begin
        step_count <= step_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= iid_pkg::op_t'(operation);
      kind_q   <= int_kind;
      cond_q   <= cond_kind;
      value_q  <= cond_value;
      num_q    <= gen_number;
      old_pc_q <= old_pc;
      cur_pc_q <= cur_pc;
      psw_q    <= psw_in;
      ecr_q    <= ecr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (state == iid_pkg::ST_EVAL) begin
      for (int i = 0; i < N; i++) begin
        pc_hit_q[i]   <= hits[i].pc_hit;
        time_hit_q[i] <= hits[i].time_hit;
        id_hit_q[i]   <= hits[i].id_hit;
      end
      any_q <= |valid_vec;
      nm_q  <= |nm_vec;
    end
  end

  always_comb begin
    match    = pc_hit_q | time_hit_q;
    first    = match & (~match + N'(1));
    id_first = id_hit_q & (~id_hit_q + N'(1));
    id_ge    = (|id_hit_q) ? ~(id_first - N'(1)) : '0;
    sel_kind = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) sel_kind = sel_kind | entries[i].kind;
    end
    table_full = entries[N-1].valid;
    check      = any_q && (nm_q || !psw_q[iid_pkg::PSW_ID]);
    fire       = check ? (|match) : nmi_pending;
    fire_kind  = check ? sel_kind : iid_pkg::KIND_NMI;
    mod_psw    = psw_q;
    mod_psw[iid_pkg::PSW_ID] = 1'b1;
    mod_psw[iid_pkg::PSW_EP] = 1'b0;
    mask_idx   = fire_kind - iid_pkg::KIND_MASK_LO;
    mask_code  = iid_pkg::MASK_CODE_LO + {1'b0, mask_idx, 4'b0000};
    disable_vec = '0;
    if ((state == iid_pkg::ST_APPLY) && (op_q == iid_pkg::OP_STEP) && check) begin
      disable_vec = first & time_hit_q;
    end
    for (int i = 0; i < N; i++) begin
      ctrl[i].take_prev   = (state == iid_pkg::ST_APPLY) && (op_q == iid_pkg::OP_ADD) &&
                            !table_full;
      ctrl[i].take_next   = (state == iid_pkg::ST_APPLY) && (op_q == iid_pkg::OP_REMOVE) &&
                            id_ge[i];
      ctrl[i].disable_gen = disable_vec[i];
    end
  end

  always_comb begin
    nmi_pending_next = nmi_pending;
    if (op_q == iid_pkg::OP_STEP) begin
      if (!check && nmi_pending) nmi_pending_next = 1'b0;
      if (fire && (fire_kind == iid_pkg::KIND_NMI) && mod_psw[iid_pkg::PSW_NP]) begin
        nmi_pending_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id     <= 8'd1;
      nmi_pending <= 1'b0;
    end else if (state == iid_pkg::ST_APPLY) begin
      nmi_pending <= nmi_pending_next;
      if ((op_q == iid_pkg::OP_ADD) && !table_full) next_id <= next_id + 8'd1;
    end
  end

  always_comb begin
    status_next    = iid_pkg::STATUS_OK;
    assigned_next  = '0;
    taken_next     = 1'b0;
    next_pc_next   = cur_pc_q;
    next_psw_next  = psw_q;
    next_ecr_next  = ecr_q;
    save_kind_next = iid_pkg::SAVE_NONE;
    save_pc_next   = '0;
    save_psw_next  = '0;
    case (op_q)
      iid_pkg::OP_ADD: begin
        if (table_full) begin
          status_next = iid_pkg::STATUS_FULL;
        end else begin
          assigned_next = next_id;
        end
      end
      iid_pkg::OP_REMOVE: begin
        if (!(|id_hit_q)) status_next = iid_pkg::STATUS_NO_GEN;
      end
      iid_pkg::OP_STEP: begin
        if (fire) begin
          taken_next = 1'b1;
          if (fire_kind == iid_pkg::KIND_RESET) begin
            next_pc_next  = '0;
            next_psw_next = iid_pkg::RESET_PSW;
            next_ecr_next = '0;
          end else if (fire_kind == iid_pkg::KIND_NMI) begin
            if (mod_psw[iid_pkg::PSW_NP]) begin
              next_psw_next = mod_psw;
            end else begin
              save_kind_next = iid_pkg::SAVE_FE;
              save_pc_next   = cur_pc_q;
              save_psw_next  = mod_psw;
              next_ecr_next  = (ecr_q & iid_pkg::ECR_LO_MASK) | iid_pkg::NMI_CODE;
              next_psw_next  = mod_psw | (32'd1 << iid_pkg::PSW_NP);
              next_pc_next   = iid_pkg::NMI_CODE;
            end
          end else begin
            save_kind_next = iid_pkg::SAVE_EI;
            save_pc_next   = cur_pc_q;
            save_psw_next  = mod_psw;
            next_ecr_next  = (ecr_q & iid_pkg::ECR_HI_MASK) | {24'd0, mask_code};
            next_psw_next  = mod_psw;
            next_pc_next   = {24'd0, mask_code};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == iid_pkg::ST_APPLY) begin
      status          <= status_next;
      assigned_number <= assigned_next;
      taken           <= taken_next;
      next_pc         <= next_pc_next;
      next_psw        <= next_psw_next;
      next_ecr        <= next_ecr_next;
      save_kind       <= save_kind_next;
      save_pc         <= save_pc_next;
      save_psw        <= save_psw_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_compacted: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec & (valid_vec + N'(1))) == '0))
    else $error("generator table is not compacted");

  a_one_disable: assert property (@(posedge clk) disable iff (rst)
    $onehot0(disable_vec))
    else $error("more than one generator disabled at once");

  a_not_taken_pass: assert property (@(posedge clk) disable iff (rst)
    (done && !taken) |-> (next_pc == cur_pc_q) && (save_kind == iid_pkg::SAVE_NONE))
    else $error("untaken result alters pc or requests a save");

  a_status_no_take: assert property (@(posedge clk) disable iff (rst)
    (done && (status != iid_pkg::STATUS_OK)) |-> !taken)
    else $error("error status with interrupt taken");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    ((state == iid_pkg::ST_APPLY) && (op_q == iid_pkg::OP_ADD) && !table_full)
      |=> entries[0].valid && (entries[0].id == $past(next_id)))
    else $error("added generator missing from head cell");
`endif

endmodule
`default_nettype wire

@@ rtl/iid_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iid_cell
// One generator slot of the chain: holds an entry, shifts from either
// neighbor and reports its own match flags.
// ----------------------------------------------------------------------------
module iid_cell (
  input  logic               clk,
  input  logic               rst,
  input  iid_pkg::cell_ctrl_t ctrl,
  input  iid_pkg::gen_entry_t prev_entry,
  input  iid_pkg::gen_entry_t next_entry,
  input  logic [31:0]        old_pc,
  input  logic [31:0]        step_count,
  input  logic [7:0]         gen_number,
  output iid_pkg::gen_entry_t entry,
  output iid_pkg::cell_hit_t  hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid   <= 1'b0;
      entry.enabled <= 1'b0;
    end else if (ctrl.take_prev) begin
      entry <= prev_entry;
    end else if (ctrl.take_next) begin
      entry <= next_entry;
    end else if (ctrl.disable_gen) begin
      entry.enabled <= 1'b0;
    end
  end

  always_comb begin
    hit.pc_hit   = entry.valid && entry.enabled && !entry.cond && (entry.value == old_pc);
    hit.time_hit = entry.valid && entry.enabled && entry.cond && (step_count > entry.value);
    hit.id_hit   = entry.valid && (entry.id == gen_number);
    hit.nm       = entry.valid && ((entry.kind == iid_pkg::KIND_RESET) ||
                                   (entry.kind == iid_pkg::KIND_NMI));
  end

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the interrupt inject and dispatch block. A driver
// feeds add, remove, step and resume transfers from a prepared queue in
// random bursts. Each accepted transfer is run through a local model of the
// generator table and interrupt entry. A monitor compares every result
// strobe, field by field, with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iid_pkg::*;

  localparam int         RESET_CYCLES   = 10;
  localparam int         TAIL_CYCLES    = 12;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         ITEM_TARGET    = 1700;
  localparam int         MAX_REPORTS    = 10;
  localparam logic [2:0] KIND_INTOV1    = KIND_MASK_LO;
  localparam logic [2:0] KIND_INTP10    = 3'd3;
  localparam logic [2:0] KIND_INTP11    = 3'd4;
  localparam logic [2:0] KIND_INTP12    = 3'd5;
  localparam logic [2:0] KIND_INTP13    = 3'd6;
  localparam logic [2:0] KIND_INTCM4    = 3'd7;
  localparam logic       COND_PC        = 1'b0;
  localparam logic       COND_TIME      = 1'b1;

  typedef struct {
    op_t         op;
    logic [2:0]  kind;
    logic        cond;
    logic [31:0] value;
    logic [7:0]  num;
    logic [31:0] old_pc;
    logic [31:0] cur_pc;
    logic [31:0] psw;
    logic [31:0] ecr;
    bit          drain;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  assigned;
    logic        taken;
    logic [31:0] pc;
    logic [31:0] psw;
    logic [31:0] ecr;
    save_t       save;
    logic [31:0] save_pc;
    logic [31:0] save_psw;
  } dispatch_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  operation = '0;
  logic [2:0]  int_kind = '0;
  logic        cond_kind = 1'b0;
  logic [31:0] cond_value = '0;
  logic [7:0]  gen_number = '0;
  logic [31:0] old_pc = '0;
  logic [31:0] cur_pc = '0;
  logic [31:0] psw_in = '0;
  logic [31:0] ecr_in = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [7:0]  assigned_number;
  logic        taken;
  logic [31:0] next_pc;
  logic [31:0] next_psw;
  logic [31:0] next_ecr;
  logic [1:0]  save_kind;
  logic [31:0] save_pc;
  logic [31:0] save_psw;

  cmd_t          cmd_q[$];
  cmd_t          cur_cmd;
  dispatch_res_t outcome_q[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  int            burst_left = 1;
  int            gap_left = 0;

  gen_entry_t    gen_tbl[NUM_GENERATORS] = '{default: '0};
  logic [7:0]    id_next = 8'd1;
  logic [31:0]   retired_steps = '0;
  logic          nmi_held = 1'b0;

  logic [7:0]    live_ids[$];
  logic [7:0]    id_ctr = 8'd1;
  logic [31:0]   pc_pool[8];
  bit            drain_next = 1'b0;

  interrupt_inject_dispatch_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .int_kind        (int_kind),
    .cond_kind       (cond_kind),
    .cond_value      (cond_value),
    .gen_number      (gen_number),
    .old_pc          (old_pc),
    .cur_pc          (cur_pc),
    .psw_in          (psw_in),
    .ecr_in          (ecr_in),
    .done            (done),
    .status          (status),
    .assigned_number (assigned_number),
    .taken           (taken),
    .next_pc         (next_pc),
    .next_psw        (next_psw),
    .next_ecr        (next_ecr),
    .save_kind       (save_kind),
    .save_pc         (save_pc),
    .save_psw        (save_psw)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic dispatch_res_t dispatch_outcome(cmd_t c);
    dispatch_res_t r;
    logic          any_gen;
    logic          have_nm;
    logic          fire;
    logic [2:0]    fire_kind;
    logic [31:0]   pswm;
    logic [31:0]   code;
    int            hit;
    r.status   = STATUS_OK;
    r.assigned = '0;
    r.taken    = 1'b0;
    r.pc       = c.cur_pc;
    r.psw      = c.psw;
    r.ecr      = c.ecr;
    r.save     = SAVE_NONE;
    r.save_pc  = '0;
    r.save_psw = '0;
    case (c.op)
      OP_ADD: begin
        if (gen_tbl[NUM_GENERATORS-1].valid) begin
          r.status = STATUS_FULL;
        end else begin
          for (int i = NUM_GENERATORS - 1; i > 0; i--) gen_tbl[i] = gen_tbl[i-1];
          gen_tbl[0] = '{valid: 1'b1, enabled: 1'b1, kind: c.kind, cond: c.cond,
                         value: c.value, id: id_next};
          r.assigned = id_next;
          id_next++;
        end
      end
      OP_REMOVE: begin
        hit = -1;
        for (int i = 0; i < NUM_GENERATORS; i++) begin
          if (hit < 0 && gen_tbl[i].valid && gen_tbl[i].id == c.num) hit = i;
        end
        if (hit < 0) begin
          r.status = STATUS_NO_GEN;
        end else begin
          for (int i = hit; i < NUM_GENERATORS - 1; i++) gen_tbl[i] = gen_tbl[i+1];
          gen_tbl[NUM_GENERATORS-1] = '0;
        end
      end
      OP_RESUME: begin
        retired_steps = '0;
      end
      default: begin
        any_gen   = 1'b0;
        have_nm   = 1'b0;
        fire      = 1'b0;
        fire_kind = KIND_RESET;
        if (retired_steps != '1) retired_steps++;
        for (int i = 0; i < NUM_GENERATORS; i++) begin
          if (gen_tbl[i].valid) begin
            any_gen = 1'b1;
            if (gen_tbl[i].kind == KIND_RESET || gen_tbl[i].kind == KIND_NMI) have_nm = 1'b1;
          end
        end
        if (any_gen && (have_nm || !c.psw[PSW_ID])) begin
          for (int i = 0; i < NUM_GENERATORS; i++) begin
            if (!fire && gen_tbl[i].valid && gen_tbl[i].enabled) begin
              if (gen_tbl[i].cond == COND_PC) begin
                if (gen_tbl[i].value == c.old_pc) begin
                  fire      = 1'b1;
                  fire_kind = gen_tbl[i].kind;
                end
              end else if (retired_steps > gen_tbl[i].value) begin
                gen_tbl[i].enabled = 1'b0;
                fire      = 1'b1;
                fire_kind = gen_tbl[i].kind;
              end
            end
          end
        end else if (nmi_held) begin
          nmi_held  = 1'b0;
          fire      = 1'b1;
          fire_kind = KIND_NMI;
        end
        if (fire) begin
          pswm         = c.psw;
          pswm[PSW_ID] = 1'b1;
          pswm[PSW_EP] = 1'b0;
          r.taken      = 1'b1;
          if (fire_kind == KIND_RESET) begin
            r.pc  = '0;
            r.psw = RESET_PSW;
            r.ecr = '0;
          end else if (fire_kind == KIND_NMI) begin
            if (pswm[PSW_NP]) begin
              nmi_held = 1'b1;
              r.psw    = pswm;
            end else begin
              r.save         = SAVE_FE;
              r.save_pc      = c.cur_pc;
              r.save_psw     = pswm;
              r.ecr          = (c.ecr & ECR_LO_MASK) | NMI_CODE;
              r.psw          = pswm;
              r.psw[PSW_NP]  = 1'b1;
              r.pc           = NMI_CODE;
            end
          end else begin
            code       = 32'(MASK_CODE_LO) + (32'(fire_kind - KIND_MASK_LO) << 4);
            r.save     = SAVE_EI;
            r.save_pc  = c.cur_pc;
            r.save_psw = pswm;
            r.ecr      = (c.ecr & ECR_HI_MASK) | code;
            r.psw      = pswm;
            r.pc       = code;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic cmd_t rand_cmd(op_t op);
    cmd_t c;
    c.op     = op;
    c.kind   = 3'($urandom);
    c.cond   = 1'($urandom);
    c.value  = $urandom;
    c.num    = 8'($urandom);
    c.old_pc = $urandom;
    c.cur_pc = $urandom;
    c.psw    = $urandom;
    c.ecr    = $urandom;
    c.drain  = 1'b0;
    return c;
  endfunction

  function automatic logic [31:0] pick_pc();
    return ($urandom_range(0, 99) < 65) ? pc_pool[$urandom_range(0, 7)] : $urandom;
  endfunction

  function automatic logic [31:0] pick_threshold();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 30);
    if (r == 7) return '1;
    return $urandom;
  endfunction

  task automatic push_cmd(cmd_t c);
    int idx;
    c.drain    = drain_next;
    drain_next = 1'b0;
    if (c.op == OP_ADD && live_ids.size() < NUM_GENERATORS) begin
      live_ids.push_front(id_ctr);
      id_ctr++;
    end else if (c.op == OP_REMOVE) begin
      idx = -1;
      foreach (live_ids[i]) if (idx < 0 && live_ids[i] == c.num) idx = i;
      if (idx >= 0) live_ids.delete(idx);
    end
    cmd_q.push_back(c);
  endtask

  task automatic add_gen(logic [2:0] kind, logic cond, logic [31:0] value);
    cmd_t c;
    c       = rand_cmd(OP_ADD);
    c.kind  = kind;
    c.cond  = cond;
    c.value = value;
    push_cmd(c);
  endtask

  task automatic add_rand();
    logic cond;
    cond = 1'($urandom);
    add_gen(3'($urandom), cond, (cond == COND_PC) ? pick_pc() : pick_threshold());
  endtask

  task automatic remove_gen(logic [7:0] num);
    cmd_t c;
    c     = rand_cmd(OP_REMOVE);
    c.num = num;
    push_cmd(c);
  endtask

  task automatic retire(logic [31:0] pc, logic [31:0] psw);
    cmd_t c;
    c        = rand_cmd(OP_STEP);
    c.old_pc = pc;
    c.psw    = psw;
    push_cmd(c);
  endtask

  task automatic retire_rand();
    logic [31:0] psw;
    psw = $urandom;
    if ($urandom_range(0, 9) < 7) psw[PSW_ID] = 1'b0;
    retire(pick_pc(), psw);
  endtask

  task automatic build_directed();
    retire(32'h0000_0100, 32'h0000_0000);
    remove_gen(8'd0);
    add_gen(KIND_INTP10, COND_PC, 32'h0000_1000);
    retire(32'h0000_1000, 32'h0000_0040);
    retire(32'h0000_1000, 32'h0000_0020);
    add_gen(KIND_NMI, COND_PC, 32'h0000_2000);
    retire(32'h0000_2000, 32'h0000_00a0);
    retire(32'h0000_2000, 32'h0000_0000);
    push_cmd(rand_cmd(OP_RESUME));
    add_gen(KIND_INTCM4, COND_TIME, 32'd2);
    repeat (4) retire(32'h0000_1000, 32'h0000_0000);
    remove_gen(8'd2);
    retire(32'h0000_2000, 32'h0000_0020);
    add_gen(KIND_RESET, COND_PC, 32'hffff_fffc);
    retire(32'hffff_fffc, 32'hffff_ffff);
    add_gen(KIND_INTOV1, COND_PC, 32'h0000_3000);
    add_gen(KIND_INTP11, COND_PC, 32'h0000_3000);
    add_gen(KIND_INTP12, COND_PC, 32'h0000_3000);
    add_gen(KIND_INTP13, COND_TIME, 32'hffff_ffff);
    add_gen(KIND_NMI, COND_TIME, 32'd0);
    add_gen(KIND_INTOV1, COND_PC, 32'h0000_0000);
    retire(32'h0000_3000, 32'h0000_0080);
  endtask

  task automatic build_number_wrap();
    while (live_ids.size() > 0) remove_gen(live_ids[0]);
    drain_next = 1'b1;
    add_rand();
    for (int n = 0; n < 260; n++) begin
      add_rand();
      if ($urandom_range(0, 3) == 0) retire_rand();
      remove_gen(live_ids[0]);
    end
    remove_gen(live_ids[0]);
  endtask

  task automatic build_random();
    int  pick;
    bit  wrapped;
    wrapped = 1'b0;
    while (cmd_q.size() < ITEM_TARGET) begin
      if (!wrapped && cmd_q.size() > 600) begin
        build_number_wrap();
        wrapped = 1'b1;
      end
      if ($urandom_range(0, 11) == 0) drain_next = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        repeat ($urandom_range(0, 3)) add_rand();
        repeat ($urandom_range(2, 12)) retire_rand();
        if ($urandom_range(0, 2) == 0) push_cmd(rand_cmd(OP_RESUME));
      end else if (pick < 8) begin
        repeat ($urandom_range(1, 3)) begin
          if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
            remove_gen(live_ids[$urandom_range(0, live_ids.size() - 1)]);
          else
            remove_gen(8'($urandom));
        end
      end else if (pick == 8) begin
        while (live_ids.size() > 0) remove_gen(live_ids[$urandom_range(0, live_ids.size() - 1)]);
        repeat ($urandom_range(1, 4)) retire_rand();
      end else begin
        repeat ($urandom_range(1, 4)) push_cmd(rand_cmd(op_t'($urandom_range(0, 3))));
      end
    end
  endtask

  always @(posedge clk) begin : drive_proc
    logic go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      go = start;
      if (start && !busy) begin
        outcome_q.push_back(dispatch_outcome(cur_cmd));
        go = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 25)
                                                    : $urandom_range(1, 9);
        end
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && outcome_q.size() != 0)) begin
          cur_cmd = cmd_q.pop_front();
          operation  <= cur_cmd.op;
          int_kind   <= cur_cmd.kind;
          cond_kind  <= cur_cmd.cond;
          cond_value <= cur_cmd.value;
          gen_number <= cur_cmd.num;
          old_pc     <= cur_cmd.old_pc;
          cur_pc     <= cur_cmd.cur_pc;
          psw_in     <= cur_cmd.psw;
          ecr_in     <= cur_cmd.ecr;
          go = 1'b1;
        end
      end
      start <= go;
    end
  end

  always @(posedge clk) begin : check_proc
    dispatch_res_t want;
    dispatch_res_t got;
    if (!rst && done) begin
      got.status   = status_t'(status);
      got.assigned = assigned_number;
      got.taken    = taken;
      got.pc       = next_pc;
      got.psw      = next_psw;
      got.ecr      = next_ecr;
      got.save     = save_t'(save_kind);
      got.save_pc  = save_pc;
      got.save_psw = save_psw;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t: result strobe with nothing pending", $time);
      end else begin
        want = outcome_q.pop_front();
        if (got.status !== want.status || got.assigned !== want.assigned ||
            got.taken !== want.taken || got.pc !== want.pc || got.psw !== want.psw ||
            got.ecr !== want.ecr || got.save !== want.save ||
            got.save_pc !== want.save_pc || got.save_psw !== want.save_psw) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: exp st=%0d num=%0d tk=%b pc=%h psw=%h ecr=%h sv=%0d spc=%h spsw=%h",
                     $time, want.status, want.assigned, want.taken, want.pc, want.psw,
                     want.ecr, want.save, want.save_pc, want.save_psw);
            $display("%0t: got st=%0d num=%0d tk=%b pc=%h psw=%h ecr=%h sv=%0d spc=%h spsw=%h",
                     $time, got.status, got.assigned, got.taken, got.pc, got.psw,
                     got.ecr, got.save, got.save_pc, got.save_psw);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pc_pool[0] = 32'h0000_0000;
    pc_pool[1] = 32'hffff_ffff;
    for (int i = 2; i < 8; i++) pc_pool[i] = $urandom;
    build_directed();
    build_random();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (cmd_q.size() != 0 || start || outcome_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
